### hdl/rll_pkg.sv
// Package for the rule language lexer: token kinds, scan modes, error codes,
// keyword table and character class helpers. No dependencies.
package rll_pkg;

  localparam int POS_BITS = 16;
  localparam int NUM_KW = 14;
  localparam int MAX_KEYWORD_LEN = 9;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_IDENT = 4'd1;
  localparam logic [3:0] M_INT   = 4'd2;
  localparam logic [3:0] M_UNIT  = 4'd3;
  localparam logic [3:0] M_EQ    = 4'd4;
  localparam logic [3:0] M_LT    = 4'd5;
  localparam logic [3:0] M_GT    = 4'd6;
  localparam logic [3:0] M_STR   = 4'd7;
  localparam logic [3:0] M_RGX   = 4'd8;
  localparam logic [3:0] M_BYTES = 4'd9;

  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_COLON   = 6'd4;
  localparam logic [5:0] K_DOLLAR  = 6'd5;
  localparam logic [5:0] K_EQ      = 6'd6;
  localparam logic [5:0] K_LT      = 6'd8;
  localparam logic [5:0] K_GT      = 6'd10;
  localparam logic [5:0] K_STAR    = 6'd12;
  localparam logic [5:0] K_STRING  = 6'd13;
  localparam logic [5:0] K_BYTESEQ = 6'd14;
  localparam logic [5:0] K_REGEX   = 6'd15;
  localparam logic [5:0] K_INT     = 6'd16;
  localparam logic [5:0] K_SIZE    = 6'd17;
  localparam logic [5:0] K_IDENT   = 6'd18;
  localparam logic [5:0] K_KW0     = 6'd19;
  localparam logic [5:0] K_DATA    = 6'd33;
  localparam logic [5:0] K_ERROR   = 6'd34;

  localparam logic [2:0] E_NONE   = 3'd0;
  localparam logic [2:0] E_CHAR   = 3'd1;
  localparam logic [2:0] E_SUFFIX = 3'd2;
  localparam logic [2:0] E_HEX    = 3'd3;
  localparam logic [2:0] E_UNTERM = 3'd4;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic [15:0] line_number;
    logic [15:0] line_start;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;
    logic        run_last;
  } token_t;

  function automatic logic [3:0] kw_len(input int k);
    case (k)
      0, 1, 8, 10: kw_len = 4'd4;
      2:           kw_len = 4'd9;
      3:           kw_len = 4'd7;
      4, 11, 12:   kw_len = 4'd3;
      6:           kw_len = 4'd6;
      7:           kw_len = 4'd5;
      default:     kw_len = 4'd2;
    endcase
  endfunction

  // Keywords are stored left-justified in nine bytes; positions past the end read as zero.
  function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
    logic [71:0] w, sh;
    case (k)
      0:       w = {"rule", 40'd0};
      1:       w = {"meta", 40'd0};
      2:       w = "condition";
      3:       w = {"content", 16'd0};
      4:       w = {"and", 48'd0};
      5:       w = {"or", 56'd0};
      6:       w = {"nocase", 24'd0};
      7:       w = {"ascii", 32'd0};
      8:       w = {"wide", 40'd0};
      9:       w = {"of", 56'd0};
      10:      w = {"them", 40'd0};
      11:      w = {"any", 48'd0};
      12:      w = {"all", 48'd0};
      default: w = {"at", 56'd0};
    endcase
    sh = w << {i, 3'b000};
    kw_char = sh[71:64];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    if (is_digit(c)) hex_val = {1'b0, 4'(c - "0")};
    else if ((c >= "a") && (c <= "f")) hex_val = {1'b0, 4'(c - "a" + 8'd10)};
    else if ((c >= "A") && (c <= "F")) hex_val = {1'b0, 4'(c - "A" + 8'd10)};
    else hex_val = 5'h10;
  endfunction

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] x);
    sat_inc = (x == POS_MAX) ? x : x + 1'b1;
  endfunction

endpackage

### hdl/rll_if.sv
// Valid/ready channel interfaces for the lexer's source bytes and tokens.
// Depends on rll_pkg.
interface rll_src_if import rll_pkg::*; (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;
  modport source (output valid, source_byte, end_of_source, input ready);
  modport sink (input valid, source_byte, end_of_source, output ready);
endinterface

interface rll_tok_if import rll_pkg::*; (input logic clk);
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [15:0] start_pos;
  logic [15:0] end_pos;
  logic [15:0] line_number;
  logic [15:0] line_start;
  logic [7:0]  data_byte;
  logic [2:0]  error_code;
  logic        run_last;
  modport source (output valid, token_kind, start_pos, end_pos, line_number, line_start,
                  data_byte, error_code, run_last, input ready);
  modport sink (input valid, token_kind, start_pos, end_pos, line_number, line_start,
                data_byte, error_code, run_last, output ready);
endinterface

### hdl/rule_language_lexer.sv
// Channel  Dir  Content
// in_      in   source_byte, end_of_source (valid/ready)
// out_     out  token fields, run_last (valid/ready)
// One byte is taken per cycle while the queue can take its tokens; its zero to two tokens
// leave from a two-entry result queue, one per cycle unless out_.ready stalls them.
// Reset is synchronous, active low, and returns the scanner to idle at position 0.
// in_.ready is low while a queued token is not popped, so a stalled output holds input.
// Depends on rll_pkg and rll_if.
module rule_language_lexer import rll_pkg::*; (
  input logic clk,
  input logic rst_n,
  rll_src_if.sink in_,
  rll_tok_if.source out_
);

  logic [3:0]  mode_r, mode_nxt;
  logic [15:0] pos_r, pos_nxt, tstart_r, tstart_nxt, line_r, line_nxt, lstart_r, lstart_nxt;
  logic [13:0] cand_r, cand_nxt;
  logic [3:0]  idlen_r, idlen_nxt, hnib_r, hnib_nxt;
  logic        half_r, half_nxt, seen_r, seen_nxt, err_r, err_nxt;
  logic [15:0] sfirst_r, sfirst_nxt, slast_r, slast_nxt;

  token_t q_r [2];
  logic [1:0] cnt_r;
  logic       rd_r;

  token_t t0, t1;
  logic [1:0] n;
  logic accept, pop;

  // Queue space: accept only when two free slots remain after this cycle's pop.
  assign pop = out_.valid && out_.ready;
  assign in_.ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);
  assign accept = in_.valid && in_.ready;
  assign out_.valid = cnt_r != 2'd0;
  assign out_.token_kind = q_r[rd_r].token_kind;
  assign out_.start_pos = q_r[rd_r].start_pos;
  assign out_.end_pos = q_r[rd_r].end_pos;
  assign out_.line_number = q_r[rd_r].line_number;
  assign out_.line_start = q_r[rd_r].line_start;
  assign out_.data_byte = q_r[rd_r].data_byte;
  assign out_.error_code = q_r[rd_r].error_code;
  assign out_.run_last = q_r[rd_r].run_last;

  always_comb begin
    logic [7:0] c;
    logic last, used;
    logic [15:0] nx;
    logic [4:0] hv;
    logic [5:0] kind, base;
    logic [15:0] s, e;
    logic [7:0] d;
    logic [2:0] ec;
    logic put_a;
    token_t tk;
    c = in_.source_byte;
    last = in_.end_of_source;
    nx = sat_inc(pos_r);
    mode_nxt = mode_r; tstart_nxt = tstart_r; line_nxt = line_r; lstart_nxt = lstart_r;
    cand_nxt = cand_r; idlen_nxt = idlen_r; hnib_nxt = hnib_r; half_nxt = half_r;
    seen_nxt = seen_r; sfirst_nxt = sfirst_r; slast_nxt = slast_r; err_nxt = err_r;
    pos_nxt = pos_r;
    t0 = '0; t1 = '0; n = 2'd0;
    used = 1'b1; hv = hex_val(c); base = K_EQ;
    kind = '0; s = '0; e = '0; d = '0; ec = E_NONE; put_a = 1'b0;
    tk = '0;
    if (accept && !err_r) begin
      pos_nxt = nx;
      // Stage A: continue the pending token.
      case (mode_r)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            for (int k = 0; k < NUM_KW; k++)
              if (idlen_r >= 4'(MAX_KEYWORD_LEN) || idlen_r >= kw_len(k) ||
                  kw_char(k, idlen_r) != c) cand_nxt[k] = 1'b0;
            idlen_nxt = (idlen_r == 4'd15) ? idlen_r : idlen_r + 4'd1;
          end else begin
            kind = K_IDENT;
            if (idlen_r <= 4'(MAX_KEYWORD_LEN))
              for (int k = NUM_KW - 1; k >= 0; k--)
                if (cand_r[k] && kw_len(k) == idlen_r) kind = K_KW0 + 6'(k);
            put_a = 1'b1; s = tstart_r; e = pos_r; mode_nxt = M_IDLE; used = 1'b0;
          end
        end
        M_INT: begin
          if (!is_digit(c)) begin
            if (c == "B" || c == "b") begin
              put_a = 1'b1; kind = K_SIZE; s = tstart_r; e = nx; mode_nxt = M_IDLE;
            end else if (c inside {"K", "k", "M", "m", "G", "g"}) begin
              mode_nxt = M_UNIT;
            end else if (is_alpha(c)) begin
              put_a = 1'b1; kind = K_ERROR; s = pos_r; e = nx; ec = E_SUFFIX;
              err_nxt = 1'b1; mode_nxt = M_IDLE;
            end else begin
              put_a = 1'b1; kind = K_INT; s = tstart_r; e = pos_r; mode_nxt = M_IDLE;
              used = 1'b0;
            end
          end
        end
        M_UNIT: begin
          put_a = 1'b1; mode_nxt = M_IDLE;
          if (c == "B" || c == "b") begin
            kind = K_SIZE; s = tstart_r; e = nx;
          end else begin
            kind = K_ERROR; s = pos_r; e = nx; ec = E_SUFFIX; err_nxt = 1'b1;
          end
        end
        M_EQ, M_LT, M_GT: begin
          if (mode_r == M_LT) base = K_LT;
          else if (mode_r == M_GT) base = K_GT;
          mode_nxt = M_IDLE; put_a = 1'b1; s = tstart_r;
          if (c == "=") begin
            kind = base + 6'd1; e = nx;
          end else begin
            kind = base; e = sat_inc(tstart_r); used = 1'b0;
          end
        end
        M_STR: begin
          if (c == "\"") begin
            put_a = 1'b1; kind = K_STRING; s = sat_inc(tstart_r); e = pos_r; mode_nxt = M_IDLE;
          end
        end
        M_RGX: begin
          if (c == "/") begin
            put_a = 1'b1; kind = K_REGEX; s = tstart_r; e = nx; mode_nxt = M_IDLE;
          end
        end
        M_BYTES: begin
          if (c == "|") begin
            mode_nxt = M_IDLE; half_nxt = 1'b0;
            if (half_r) begin
              t0.token_kind = K_DATA; t0.start_pos = slast_r;
              t0.end_pos = sat_inc(slast_r); t0.data_byte = {hnib_r, 4'd0};
              t0.line_number = line_r; t0.line_start = lstart_r;
              n = 2'd1;
            end
            put_a = 1'b1; kind = K_BYTESEQ;
            s = seen_r ? sfirst_r : pos_r;
            e = seen_r ? sat_inc(slast_r) : pos_r;
          end else if (c != " ") begin
            if (hv[4]) begin
              put_a = 1'b1; kind = K_ERROR; s = pos_r; e = nx; ec = E_HEX;
              err_nxt = 1'b1; mode_nxt = M_IDLE;
            end else begin
              slast_nxt = pos_r;
              if (!half_r) begin
                hnib_nxt = hv[3:0]; half_nxt = 1'b1; seen_nxt = 1'b1;
                if (!seen_r) sfirst_nxt = pos_r;
              end else begin
                put_a = 1'b1; kind = K_DATA; s = slast_r; e = nx;
                d = {hnib_r, hv[3:0]}; half_nxt = 1'b0;
              end
            end
          end
        end
        default: used = 1'b0;
      endcase
      if (put_a) begin
        tk = '0; tk.token_kind = kind; tk.start_pos = s; tk.end_pos = e;
        tk.data_byte = d; tk.error_code = ec;
        tk.line_number = line_r; tk.line_start = lstart_r;
        if (n == 2'd0) t0 = tk; else t1 = tk;
        n = n + 2'd1;
      end
      // Stage B: start a new token with this byte.
      put_a = 1'b0; d = '0; ec = E_NONE; s = pos_r; e = nx; kind = '0;
      if (!used && !err_nxt) begin
        tstart_nxt = pos_r;
        case (c)
          "(": begin put_a = 1'b1; kind = K_LPAREN; end
          ")": begin put_a = 1'b1; kind = K_RPAREN; end
          "{": begin put_a = 1'b1; kind = K_LBRACE; end
          "}": begin put_a = 1'b1; kind = K_RBRACE; end
          ":": begin put_a = 1'b1; kind = K_COLON; end
          "$": begin put_a = 1'b1; kind = K_DOLLAR; end
          "*": begin put_a = 1'b1; kind = K_STAR; end
          "=": begin if (last) begin put_a = 1'b1; kind = K_EQ; end else mode_nxt = M_EQ; end
          "<": begin if (last) begin put_a = 1'b1; kind = K_LT; end else mode_nxt = M_LT; end
          ">": begin if (last) begin put_a = 1'b1; kind = K_GT; end else mode_nxt = M_GT; end
          " ", "\t", 8'd0: ;
          "\n": begin
            if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
            lstart_nxt = nx;
          end
          "\"": mode_nxt = M_STR;
          "/": mode_nxt = M_RGX;
          "|": begin
            mode_nxt = M_BYTES; seen_nxt = 1'b0; half_nxt = 1'b0; hnib_nxt = '0;
            sfirst_nxt = '0; slast_nxt = '0;
          end
          default: begin
            if (is_digit(c)) mode_nxt = M_INT;
            else if (is_alpha(c)) begin
              mode_nxt = M_IDENT; idlen_nxt = 4'd1;
              for (int k = 0; k < NUM_KW; k++)
                cand_nxt[k] = (kw_char(k, 4'd0) == c);
            end else begin
              put_a = 1'b1; kind = K_ERROR; ec = E_CHAR; err_nxt = 1'b1; mode_nxt = M_IDLE;
            end
          end
        endcase
      end
      // Stage C: end of source flushes the pending token.
      if (last && !err_nxt) begin
        case (mode_nxt)
          M_IDENT: begin
            kind = K_IDENT;
            if (idlen_nxt <= 4'(MAX_KEYWORD_LEN))
              for (int k = NUM_KW - 1; k >= 0; k--)
                if (cand_nxt[k] && kw_len(k) == idlen_nxt) kind = K_KW0 + 6'(k);
            put_a = 1'b1; s = tstart_nxt; e = nx;
          end
          M_INT: begin put_a = 1'b1; kind = K_INT; s = tstart_nxt; e = nx; end
          M_UNIT: begin
            put_a = 1'b1; kind = K_ERROR; s = nx; e = nx; ec = E_SUFFIX; err_nxt = 1'b1;
          end
          M_STR, M_RGX, M_BYTES: begin
            put_a = 1'b1; kind = K_ERROR; s = tstart_nxt; e = nx; ec = E_UNTERM;
            err_nxt = 1'b1;
          end
          default: ;
        endcase
        mode_nxt = M_IDLE;
      end
      if (put_a && n != 2'd2) begin
        tk = '0; tk.token_kind = kind; tk.start_pos = s; tk.end_pos = e;
        tk.data_byte = d; tk.error_code = ec;
        tk.line_number = line_nxt; tk.line_start = lstart_nxt;
        if (n == 2'd0) t0 = tk; else t1 = tk;
        n = n + 2'd1;
      end
      if (n == 2'd1) t0.run_last = 1'b1;
      if (n == 2'd2) t1.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; pos_r <= '0; tstart_r <= '0; line_r <= '0; lstart_r <= '0;
      cand_r <= '1; idlen_r <= '0; hnib_r <= '0; half_r <= 1'b0; seen_r <= 1'b0;
      sfirst_r <= '0; slast_r <= '0; err_r <= 1'b0;
      cnt_r <= '0; rd_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt; pos_r <= pos_nxt; tstart_r <= tstart_nxt; line_r <= line_nxt;
      lstart_r <= lstart_nxt; cand_r <= cand_nxt; idlen_r <= idlen_nxt; hnib_r <= hnib_nxt;
      half_r <= half_nxt; seen_r <= seen_nxt; sfirst_r <= sfirst_nxt; slast_r <= slast_nxt;
      err_r <= err_nxt;
      cnt_r <= cnt_r - {1'b0, pop} + n;
      if (pop) rd_r <= ~rd_r;
    end
  end

  // Writes land after the surviving entry; queue is empty or one deep on accept.
  always_ff @(posedge clk) begin
    logic wp;
    wp = rd_r ^ pop ^ ((cnt_r == 2'd1) && !pop);
    if (n != 2'd0) q_r[wp] <= t0;
    if (n == 2'd2) q_r[~wp] <= t1;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("result queue overflow");
  a_err: assert property (@(posedge clk) disable iff (!rst_n) err_r && accept |-> n == 2'd0)
    else $error("token after error");
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(pos_r)) else $error("position moved without a byte");

endmodule
